### rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert that a property holds on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// assert that a condition implies a consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) else $error(msg);
`endif

### rtl/arp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_pkg
// shared constants for the arp resolver
// ----------------------------------------------------------------------------
package arp_pkg;
	localparam int CACHE_ENTRIES_DEF = 16;
	localparam int REQUEST_SLOTS_DEF = 8;
	localparam int PENDING_DATAGRAMS_DEF = 16;
	localparam int AGE_W = 17;
	localparam logic [AGE_W-1:0] AGE_MAX = '1;
	localparam logic [47:0] BCAST_MAC = '1;
	localparam logic [15:0] LIFETIME_RST = 16'd30000;
	localparam logic [15:0] HOLDOFF_RST = 16'd5000;
	localparam logic [1:0] CMD_SEND = 2'd0;
	localparam logic [1:0] CMD_RECV = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;
	localparam logic [1:0] CMD_RSVD = 2'd3;
	localparam logic [2:0] KIND_FRAME = 3'd1;
	localparam logic [2:0] KIND_REQ = 3'd2;
	localparam logic [2:0] KIND_REPLY = 3'd3;
	localparam logic [2:0] KIND_UP = 3'd4;
	localparam logic [1:0] REG_MAC = 2'd0;
	localparam logic [1:0] REG_IP = 2'd1;
	localparam logic [1:0] REG_LIFE = 2'd2;
	localparam logic [1:0] REG_HOLD = 2'd3;
endpackage

### rtl/arp_resolver_with_pending_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_resolver_with_pending_queue
// arp cache, request holdoff table and pending datagram queue
// ----------------------------------------------------------------------------
// steps while busy: send miss cache scan, write state, request scan, request write, done;
// send hit cache scan, hit emit, done; arp receive cache scan, cache write, pending scan,
// flush, reply, done; tick cache aging, request aging, done; ipv4 receive up, done; ignored
// item done; one read per cycle per memory; results one per cycle, receiver cannot stall
// throughput: one item at a time, busy is high from accept until done
// reset: asynchronous active low, clears valid bits, config to defaults
module arp_resolver_with_pending_queue #(
	parameter int CACHE_ENTRIES = arp_pkg::CACHE_ENTRIES_DEF,
	parameter int REQUEST_SLOTS = arp_pkg::REQUEST_SLOTS_DEF,
	parameter int PENDING_DATAGRAMS = arp_pkg::PENDING_DATAGRAMS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [7:0]  datagram_tag,
	input  logic [31:0] hop_addr,
	input  logic [47:0] frame_dst_mac,
	input  logic        frame_is_ipv4,
	input  logic        parse_ok,
	input  logic        arp_is_request,
	input  logic [31:0] arp_sender_ip,
	input  logic [47:0] arp_sender_mac,
	input  logic [31:0] arp_target_ip,
	input  logic [15:0] elapsed_ms,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data,
	output logic        out_valid,
	output logic [2:0]  out_kind,
	output logic [47:0] out_dst_mac,
	output logic [7:0]  out_tag,
	output logic [31:0] out_target_ip,
	output logic [47:0] out_target_mac,
	output logic        last
);
`include "assert_macros.svh"
	localparam int CW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int RW = (REQUEST_SLOTS > 1) ? $clog2(REQUEST_SLOTS) : 1;
	localparam int PW = (PENDING_DATAGRAMS > 1) ? $clog2(PENDING_DATAGRAMS) : 1;
	localparam int AW = arp_pkg::AGE_W;
	// largest of the three depths sets the scan counter width
	localparam int MAXD = (CACHE_ENTRIES > REQUEST_SLOTS) ?
		((CACHE_ENTRIES > PENDING_DATAGRAMS) ? CACHE_ENTRIES : PENDING_DATAGRAMS) :
		((REQUEST_SLOTS > PENDING_DATAGRAMS) ? REQUEST_SLOTS : PENDING_DATAGRAMS);
	localparam int XW = $clog2(MAXD + 1);

	// sequencer states
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CSCAN = 4'd1;  // cache scan: find / free / oldest
	localparam logic [3:0] ST_CWR = 4'd2;    // cache write or hit emit
	localparam logic [3:0] ST_RSCAN = 4'd3;  // request table scan
	localparam logic [3:0] ST_RWR = 4'd4;    // request write, pending push and request emit
	localparam logic [3:0] ST_PSCAN = 4'd5;  // pending compaction
	localparam logic [3:0] ST_REPLY = 4'd6;  // arp reply emit
	localparam logic [3:0] ST_CTICK = 4'd7;  // cache aging
	localparam logic [3:0] ST_RTICK = 4'd8;  // request aging
	localparam logic [3:0] ST_DONE = 4'd9;
	localparam logic [3:0] ST_UP = 4'd10;    // deliver ipv4 datagram up
	localparam logic [3:0] ST_PFLUSH = 4'd11; // push out the held release

	logic [3:0] state_q;

	// configuration
	logic [47:0] own_mac_q;
	logic [31:0] own_ip_q;
	logic [15:0] life_q, hold_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q <= '0;
			own_ip_q <= '0;
			life_q <= arp_pkg::LIFETIME_RST;
			hold_q <= arp_pkg::HOLDOFF_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				arp_pkg::REG_MAC: own_mac_q <= cfg_data;
				arp_pkg::REG_IP: own_ip_q <= cfg_data[31:0];
				arp_pkg::REG_LIFE: life_q <= cfg_data[15:0];
				arp_pkg::REG_HOLD: hold_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// captured item
	logic [1:0]  cmd_q;
	logic [7:0]  tag_q;
	logic [31:0] ip_q;      // lookup ip: next hop or arp sender
	logic [47:0] smac_q;
	logic        reply_q;   // reply due at end
	logic [15:0] dt_q;

	// memories: valid bits in flops, payload in synchronous arrays
	logic [CACHE_ENTRIES-1:0] cv_q;
	logic [31:0] c_ip_mem [CACHE_ENTRIES];
	logic [47:0] c_mac_mem [CACHE_ENTRIES];
	logic [AW-1:0] c_age_mem [CACHE_ENTRIES];
	logic [REQUEST_SLOTS-1:0] rv_q;
	logic [31:0] r_ip_mem [REQUEST_SLOTS];
	logic [AW-1:0] r_age_mem [REQUEST_SLOTS];
	logic [PENDING_DATAGRAMS-1:0] pv_q;
	logic [31:0] p_ip_mem [PENDING_DATAGRAMS];
	logic [7:0] p_tag_mem [PENDING_DATAGRAMS];

	// read ports, registered data
	logic [CW-1:0] c_ra;
	logic [RW-1:0] r_ra;
	logic [PW-1:0] p_ra;
	logic [31:0] c_ip_rd, r_ip_rd, p_ip_rd;
	logic [47:0] c_mac_rd;
	logic [AW-1:0] c_age_rd, r_age_rd;
	logic [7:0] p_tag_rd;

	// write ports
	logic c_we, r_we, p_we;
	logic [CW-1:0] c_wa;
	logic [RW-1:0] r_wa;
	logic [PW-1:0] p_wa;
	logic [31:0] c_wip, r_wip, p_wip;
	logic [47:0] c_wmac;
	logic [AW-1:0] c_wage, r_wage;
	logic [7:0] p_wtag;

	always_ff @(posedge clk) begin
		if (c_we) begin
			c_ip_mem[c_wa] <= c_wip;
			c_mac_mem[c_wa] <= c_wmac;
			c_age_mem[c_wa] <= c_wage;
		end
		c_ip_rd <= c_ip_mem[c_ra];
		c_mac_rd <= c_mac_mem[c_ra];
		c_age_rd <= c_age_mem[c_ra];
	end
	always_ff @(posedge clk) begin
		if (r_we) begin
			r_ip_mem[r_wa] <= r_wip;
			r_age_mem[r_wa] <= r_wage;
		end
		r_ip_rd <= r_ip_mem[r_ra];
		r_age_rd <= r_age_mem[r_ra];
	end
	always_ff @(posedge clk) begin
		if (p_we) begin
			p_ip_mem[p_wa] <= p_wip;
			p_tag_mem[p_wa] <= p_wtag;
		end
		p_ip_rd <= p_ip_mem[p_ra];
		p_tag_rd <= p_tag_mem[p_ra];
	end

	// scan counters: issue index cnt_q, data for cnt_q-1 arrives with rd_ok_s1
	logic [XW-1:0] cnt_q;      // wide enough for any of the three depths
	logic [XW-1:0] idx_s1;     // index of the data now on the read ports
	logic        rd_ok_s1;
	logic [PW:0] wp_q;         // pending write pointer during compaction

	// cache scan results
	logic        hit_q;
	logic [CW-1:0] hit_idx_q;
	logic [47:0] hit_mac_q;
	logic        free_q;
	logic [CW-1:0] free_idx_q;
	logic [CW-1:0] old_idx_q;
	logic [AW-1:0] old_age_q;
	logic        old_set_q;
	// request scan results
	logic        rhit_q, rfree_q, rold_set_q;
	logic [RW-1:0] rfree_idx_q, rold_idx_q;
	logic [AW-1:0] rold_age_q;

	logic        accept;
	assign accept = start && !busy;
	assign busy = (state_q != ST_IDLE);

	// address selection
	always_comb begin
		c_ra = cnt_q[CW-1:0];
		r_ra = cnt_q[RW-1:0];
		p_ra = cnt_q[PW-1:0];
	end

	// saturating age add
	logic [AW:0] c_sum, r_sum;
	logic [AW-1:0] c_aged, r_aged;
	always_comb begin
		c_sum = {1'b0, c_age_rd} + {{(AW-15){1'b0}}, dt_q};
		r_sum = {1'b0, r_age_rd} + {{(AW-15){1'b0}}, dt_q};
		c_aged = c_sum[AW] ? arp_pkg::AGE_MAX : c_sum[AW-1:0];
		r_aged = r_sum[AW] ? arp_pkg::AGE_MAX : r_sum[AW-1:0];
	end

	// write port control
	logic c_sel_valid;
	logic [CW-1:0] c_sel;
	always_comb begin
		c_sel_valid = 1'b1;
		c_sel = hit_q ? hit_idx_q : (free_q ? free_idx_q : old_idx_q);
		c_we = 1'b0; c_wa = c_sel; c_wip = ip_q; c_wmac = smac_q; c_wage = '0;
		r_we = 1'b0; r_wa = rfree_q ? rfree_idx_q : rold_idx_q; r_wip = ip_q;
		r_wage = '0;
		p_we = 1'b0; p_wa = wp_q[PW-1:0]; p_wip = p_ip_rd; p_wtag = p_tag_rd;
		case (state_q)
			ST_CWR: c_we = (cmd_q == arp_pkg::CMD_RECV);
			ST_RWR: begin
				r_we = !rhit_q;
				p_we = !pv_q[PENDING_DATAGRAMS-1];
				p_wa = wp_q[PW-1:0];
				p_wip = ip_q;
				p_wtag = tag_q;
			end
			ST_PSCAN: p_we = rd_ok_s1 && pv_q[idx_s1[PW-1:0]] && (p_ip_rd != ip_q);
			ST_CTICK: begin
				c_we = rd_ok_s1 && cv_q[idx_s1[CW-1:0]];
				c_wa = idx_s1[CW-1:0];
				c_wip = c_ip_rd;
				c_wmac = c_mac_rd;
				c_wage = c_aged;
			end
			ST_RTICK: begin
				r_we = rd_ok_s1 && rv_q[idx_s1[RW-1:0]];
				r_wa = idx_s1[RW-1:0];
				r_wip = r_ip_rd;
				r_wage = r_aged;
			end
			default: ;
		endcase
	end

	// result strobe and fields
	logic        ov_d, last_d;
	logic [2:0]  kind_d;
	logic [47:0] dst_d, tmac_d;
	logic [7:0]  otag_d;
	logic [31:0] tip_d;
	always_comb begin
		ov_d = 1'b0; last_d = 1'b0; kind_d = '0; dst_d = '0; tmac_d = '0;
		otag_d = '0; tip_d = '0;
		case (state_q)
			ST_UP: begin
				ov_d = 1'b1; last_d = 1'b1; kind_d = arp_pkg::KIND_UP; otag_d = tag_q;
			end
			ST_CWR: if (cmd_q == arp_pkg::CMD_SEND && hit_q) begin
				ov_d = 1'b1; last_d = 1'b1; kind_d = arp_pkg::KIND_FRAME;
				dst_d = hit_mac_q; otag_d = tag_q;
			end
			ST_RWR: if (!rhit_q) begin
				ov_d = 1'b1; last_d = 1'b1; kind_d = arp_pkg::KIND_REQ;
				dst_d = arp_pkg::BCAST_MAC; tip_d = ip_q;
			end
			ST_PSCAN: if (rd_ok_s1 && pv_q[idx_s1[PW-1:0]] && p_ip_rd == ip_q) begin
				// released frame, held by the output stage until the next release or the end of the scan
				ov_d = 1'b1; kind_d = arp_pkg::KIND_FRAME;
				dst_d = smac_q; otag_d = p_tag_rd;
			end
			ST_REPLY: if (reply_q) begin
				ov_d = 1'b1; last_d = 1'b1; kind_d = arp_pkg::KIND_REPLY;
				dst_d = smac_q; tip_d = ip_q; tmac_d = smac_q;
			end
			default: ;
		endcase
	end

	// release results are held in the output stage so that last can be known
	logic        hv_q;
	logic [47:0] hdst_q;
	logic [7:0]  htag_q;
	logic        pend_out;
	always_comb pend_out = (state_q == ST_PSCAN) && ov_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			hv_q <= 1'b0;
		end else begin
			out_valid <= 1'b0;
			if (pend_out) begin
				// a new release pushes the held one out as non-final
				if (hv_q) begin
					out_valid <= 1'b1;
				end
				hv_q <= 1'b1;
			end else if (hv_q && (state_q != ST_PSCAN)) begin
				out_valid <= 1'b1;
				hv_q <= 1'b0;
			end else if (ov_d && state_q != ST_PSCAN) begin
				out_valid <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_out) begin
			hdst_q <= dst_d;
			htag_q <= otag_d;
			if (hv_q) begin
				out_kind <= arp_pkg::KIND_FRAME; out_dst_mac <= hdst_q;
				out_tag <= htag_q; out_target_ip <= '0; out_target_mac <= '0;
				last <= 1'b0;
			end
		end else if (hv_q && state_q != ST_PSCAN) begin
			// final release: last unless the arp reply follows
			out_kind <= arp_pkg::KIND_FRAME; out_dst_mac <= hdst_q;
			out_tag <= htag_q; out_target_ip <= '0; out_target_mac <= '0;
			last <= !reply_q;
		end else begin
			out_kind <= kind_d; out_dst_mac <= dst_d; out_tag <= otag_d;
			out_target_ip <= tip_d; out_target_mac <= tmac_d; last <= last_d;
		end
	end

	// sequencer
	logic [CW-1:0] ci;
	logic [RW-1:0] ri;
	logic [PW-1:0] pi;
	always_comb begin
		ci = idx_s1[CW-1:0];
		ri = idx_s1[RW-1:0];
		pi = idx_s1[PW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cv_q <= '0;
			rv_q <= '0;
			pv_q <= '0;
			cnt_q <= '0;
			rd_ok_s1 <= 1'b0;
			idx_s1 <= '0;
			wp_q <= '0;
		end else begin
			rd_ok_s1 <= 1'b0;
			idx_s1 <= cnt_q;
			case (state_q)
				ST_IDLE: if (accept) begin
					cnt_q <= '0;
					hit_q <= 1'b0; free_q <= 1'b0; old_set_q <= 1'b0;
					rhit_q <= 1'b0; rfree_q <= 1'b0; rold_set_q <= 1'b0;
					cmd_q <= cmd; tag_q <= datagram_tag; dt_q <= elapsed_ms;
					smac_q <= arp_sender_mac;
					ip_q <= (cmd == arp_pkg::CMD_SEND) ? hop_addr : arp_sender_ip;
					reply_q <= arp_is_request && (arp_target_ip == own_ip_q);
					case (cmd)
						arp_pkg::CMD_SEND: state_q <= ST_CSCAN;
						arp_pkg::CMD_RECV: begin
							if ((frame_dst_mac == own_mac_q ||
								frame_dst_mac == arp_pkg::BCAST_MAC) && parse_ok) begin
								if (frame_is_ipv4) begin
									state_q <= ST_UP;
								end else begin
									state_q <= ST_CSCAN;
								end
							end else begin
								state_q <= ST_DONE;
							end
						end
						arp_pkg::CMD_TICK: state_q <= ST_CTICK;
						default: state_q <= ST_DONE;
					endcase
				end
				ST_UP: state_q <= ST_DONE;
				ST_CSCAN: begin
					if (cnt_q < XW'(CACHE_ENTRIES)) begin
						cnt_q <= cnt_q + 1'b1;
						rd_ok_s1 <= 1'b1;
					end
					if (rd_ok_s1) begin
						if (cv_q[ci]) begin
							if (c_ip_rd == ip_q && !hit_q) begin
								hit_q <= 1'b1; hit_idx_q <= ci; hit_mac_q <= c_mac_rd;
							end
							if (!old_set_q || c_age_rd > old_age_q) begin
								old_set_q <= 1'b1; old_idx_q <= ci; old_age_q <= c_age_rd;
							end
						end else if (!free_q) begin
							free_q <= 1'b1; free_idx_q <= ci;
						end
						if (idx_s1 == XW'(CACHE_ENTRIES - 1)) state_q <= ST_CWR;
					end
				end
				ST_CWR: begin
					cnt_q <= '0;
					wp_q <= '0;
					if (cmd_q == arp_pkg::CMD_RECV) begin
						cv_q[c_sel] <= c_sel_valid;
						state_q <= ST_PSCAN;
					end else if (hit_q) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_RSCAN;
					end
				end
				ST_RSCAN: begin
					if (cnt_q < XW'(REQUEST_SLOTS)) begin
						cnt_q <= cnt_q + 1'b1;
						rd_ok_s1 <= 1'b1;
					end
					if (rd_ok_s1) begin
						if (rv_q[ri]) begin
							if (r_ip_rd == ip_q) rhit_q <= 1'b1;
							if (!rold_set_q || r_age_rd > rold_age_q) begin
								rold_set_q <= 1'b1; rold_idx_q <= ri; rold_age_q <= r_age_rd;
							end
						end else if (!rfree_q) begin
							rfree_q <= 1'b1; rfree_idx_q <= ri;
						end
						if (idx_s1 == XW'(REQUEST_SLOTS - 1)) begin
							state_q <= ST_RWR;
							// push position: first free pending slot (queue is packed)
							wp_q <= '0;
							for (int k = PENDING_DATAGRAMS - 1; k >= 0; k--)
								if (!pv_q[k]) wp_q <= (PW+1)'(k);
						end
					end
				end
				ST_RWR: begin
					if (!rhit_q) rv_q[r_wa] <= 1'b1;
					if (!pv_q[PENDING_DATAGRAMS-1]) pv_q[wp_q[PW-1:0]] <= 1'b1;
					state_q <= ST_DONE;
				end
				ST_PSCAN: begin
					if (cnt_q < XW'(PENDING_DATAGRAMS)) begin
						cnt_q <= cnt_q + 1'b1;
						rd_ok_s1 <= 1'b1;
					end
					if (rd_ok_s1) begin
						if (pv_q[pi] && p_ip_rd != ip_q) wp_q <= wp_q + 1'b1;
						if (idx_s1 == XW'(PENDING_DATAGRAMS - 1)) begin
							for (int k = 0; k < PENDING_DATAGRAMS; k++)
								pv_q[k] <= (PW+1)'(k) < (wp_q +
									((pv_q[pi] && p_ip_rd != ip_q) ? 1'b1 : 1'b0));
							state_q <= ST_PFLUSH;
						end
					end
				end
				ST_PFLUSH: state_q <= ST_REPLY;
				ST_REPLY: state_q <= ST_DONE;
				ST_CTICK: begin
					if (cnt_q < XW'(CACHE_ENTRIES)) begin
						cnt_q <= cnt_q + 1'b1;
						rd_ok_s1 <= 1'b1;
					end
					if (rd_ok_s1) begin
						if (cv_q[ci] && c_aged > {1'b0, life_q}) cv_q[ci] <= 1'b0;
						if (idx_s1 == XW'(CACHE_ENTRIES - 1)) begin
							cnt_q <= '0;
							state_q <= ST_RTICK;
						end
					end
				end
				ST_RTICK: begin
					if (cnt_q < XW'(REQUEST_SLOTS)) begin
						cnt_q <= cnt_q + 1'b1;
						rd_ok_s1 <= 1'b1;
					end
					if (rd_ok_s1) begin
						if (rv_q[ri] && r_aged > {1'b0, hold_q}) rv_q[ri] <= 1'b0;
						if (idx_s1 == XW'(REQUEST_SLOTS - 1)) state_q <= ST_DONE;
					end
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_CLK(a_no_out_idle, clk, arst_n,
		!(state_q == ST_IDLE && hv_q), "held release left while idle")
	`ASSERT_NEXT(a_accept_busy, clk, arst_n,
		accept && cmd != arp_pkg::CMD_RECV, busy, "item accepted without going busy")
	`ASSERT_NEXT(a_flush_clears, clk, arst_n,
		state_q == ST_PFLUSH, !hv_q, "held release not flushed")
	`ASSERT_NEXT(a_done_idle, clk, arst_n,
		state_q == ST_DONE, state_q == ST_IDLE, "done not followed by idle")
endmodule

### verif/tb_arp_resolver_with_pending_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arp_resolver_with_pending_queue
// self-checking bench: directed table then constrained-by-hand random items,
// each result compared against a behavioral model of cache, holdoff table and
// pending queue kept inside the bench
// ----------------------------------------------------------------------------
module tb_arp_resolver_with_pending_queue;
	localparam int NC = arp_pkg::CACHE_ENTRIES_DEF;
	localparam int NR = arp_pkg::REQUEST_SLOTS_DEF;
	localparam int NP = arp_pkg::PENDING_DATAGRAMS_DEF;
	localparam int SETTLE = 80;
	localparam longint LIMIT = 400000;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  tag;
		logic [31:0] hop;
		logic [47:0] fdst;
		logic        is_ipv4;
		logic        ok;
		logic        is_req;
		logic [31:0] sip;
		logic [47:0] smac;
		logic [31:0] tip;
		logic [15:0] dt;
	} arp_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [47:0] dst;
		logic [7:0]  tag;
		logic [31:0] tip;
		logic [47:0] tmac;
		logic        last;
	} arp_frame_t;

	// directed row: item plus an optionally typed-in last result
	typedef struct packed {
		arp_item_t  item;
		logic       has_typed;
		arp_frame_t typed;
	} arp_row_t;

	logic        clk, arst_n;
	logic        start, busy;
	logic [1:0]  cmd;
	logic [7:0]  datagram_tag;
	logic [31:0] hop_addr;
	logic [47:0] frame_dst_mac;
	logic        frame_is_ipv4, parse_ok, arp_is_request;
	logic [31:0] arp_sender_ip;
	logic [47:0] arp_sender_mac;
	logic [31:0] arp_target_ip;
	logic [15:0] elapsed_ms;
	logic        cfg_valid, cfg_ready;
	logic [1:0]  cfg_index;
	logic [47:0] cfg_data;
	logic        out_valid;
	logic [2:0]  out_kind;
	logic [47:0] out_dst_mac;
	logic [7:0]  out_tag;
	logic [31:0] out_target_ip;
	logic [47:0] out_target_mac;
	logic        last;

	arp_resolver_with_pending_queue DUT (.*);

	// model state
	logic [47:0] m_mac;
	logic [31:0] m_ip;
	logic [15:0] m_life, m_hold;
	logic        c_v[NC];
	logic [31:0] c_ip[NC];
	logic [47:0] c_mac[NC];
	logic [16:0] c_age[NC];
	logic        r_v[NR];
	logic [31:0] r_ip[NR];
	logic [16:0] r_age[NR];
	int          pend_n;
	logic [31:0] p_ip[NP];
	logic [7:0]  p_tag[NP];

	arp_frame_t expected_frames[$];
	int         err_count = 0;
	longint     cycle = 0;
	bit         quiet = 0;
	// pool of addresses so sends, replies and cache hits collide often
	logic [31:0] ip_pool[8];
	logic [47:0] mac_pool[4];

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic [16:0] sat_add(logic [16:0] a, logic [15:0] d);
		logic [17:0] s;
		s = a + d;
		return (s > arp_pkg::AGE_MAX) ? arp_pkg::AGE_MAX : s[16:0];
	endfunction

	function automatic arp_frame_t mk(logic [2:0] k, logic [47:0] d, logic [7:0] t,
		logic [31:0] ti, logic [47:0] tm);
		arp_frame_t f;
		f.kind = k; f.dst = d; f.tag = t; f.tip = ti; f.tmac = tm; f.last = 0;
		return f;
	endfunction

	// learn a mapping: refresh, free slot, or evict the oldest
	task automatic learn_mapping(logic [31:0] ip, logic [47:0] mac);
		int slot;
		slot = -1;
		for (int i = 0; i < NC; i++)
			if (slot < 0 && c_v[i] && c_ip[i] == ip) slot = i;
		for (int i = 0; i < NC; i++)
			if (slot < 0 && !c_v[i]) slot = i;
		if (slot < 0) begin
			slot = 0;
			for (int i = 1; i < NC; i++)
				if (c_age[i] > c_age[slot]) slot = i;
		end
		c_v[slot] = 1; c_ip[slot] = ip; c_mac[slot] = mac; c_age[slot] = 0;
	endtask

	function automatic bit open_request(logic [31:0] ip);
		int slot;
		slot = -1;
		for (int i = 0; i < NR; i++)
			if (r_v[i] && r_ip[i] == ip) return 0;
		for (int i = 0; i < NR; i++)
			if (slot < 0 && !r_v[i]) slot = i;
		if (slot < 0) begin
			slot = 0;
			for (int i = 1; i < NR; i++)
				if (r_age[i] > r_age[slot]) slot = i;
		end
		r_v[slot] = 1; r_ip[slot] = ip; r_age[slot] = 0;
		return 1;
	endfunction

	// predicts the frames caused by one item and queues them
	task automatic resolve_item(arp_item_t it);
		arp_frame_t res[$];
		int hit, w;
		hit = -1;
		case (it.cmd)
			arp_pkg::CMD_SEND: begin
				for (int i = 0; i < NC; i++)
					if (hit < 0 && c_v[i] && c_ip[i] == it.hop) hit = i;
				if (hit >= 0) res = {res, mk(arp_pkg::KIND_FRAME, c_mac[hit], it.tag, 0, 0)};
				else begin
					if (pend_n < NP) begin
						p_ip[pend_n] = it.hop; p_tag[pend_n] = it.tag; pend_n++;
					end
					if (open_request(it.hop))
						res = {res, mk(arp_pkg::KIND_REQ, arp_pkg::BCAST_MAC, 0, it.hop, 0)};
				end
			end
			arp_pkg::CMD_RECV: begin
				if ((it.fdst == m_mac || it.fdst == arp_pkg::BCAST_MAC) && it.ok) begin
					if (it.is_ipv4) res = {res, mk(arp_pkg::KIND_UP, 0, it.tag, 0, 0)};
					else begin
						learn_mapping(it.sip, it.smac);
						// release matching datagrams in order, compact the rest
						w = 0;
						for (int i = 0; i < pend_n; i++) begin
							if (p_ip[i] == it.sip)
								res = {res, mk(arp_pkg::KIND_FRAME, it.smac, p_tag[i], 0, 0)};
							else begin
								p_ip[w] = p_ip[i]; p_tag[w] = p_tag[i]; w++;
							end
						end
						pend_n = w;
						if (it.is_req && it.tip == m_ip)
							res = {res, mk(arp_pkg::KIND_REPLY, it.smac, 0, it.sip, it.smac)};
					end
				end
			end
			arp_pkg::CMD_TICK: begin
				for (int i = 0; i < NC; i++) if (c_v[i]) begin
					c_age[i] = sat_add(c_age[i], it.dt);
					if (c_age[i] > m_life) c_v[i] = 0;
				end
				for (int i = 0; i < NR; i++) if (r_v[i]) begin
					r_age[i] = sat_add(r_age[i], it.dt);
					if (r_age[i] > m_hold) r_v[i] = 0;
				end
			end
			default: ;
		endcase
		if (res.size() > 0) res[res.size()-1].last = 1;
		expected_frames = {expected_frames, res};
	endtask

	task automatic report(string what, arp_frame_t exp_f, arp_frame_t got);
		err_count++;
		if (err_count <= 10)
			$display("mismatch %s: expected %h got %h", what, exp_f, got);
	endtask

	// result checker: results cannot be held off, compare on every strobe
	always @(posedge clk) begin
		arp_frame_t got, exp_f;
		if (arst_n && out_valid) begin
			got = {out_kind, out_dst_mac, out_tag, out_target_ip, out_target_mac, last};
			if (expected_frames.size() == 0) report("unexpected", '0, got);
			else begin
				exp_f = expected_frames.pop_front();
				if (got.kind != exp_f.kind) report("kind", exp_f, got);
				else if (got.dst != exp_f.dst) report("dst_mac", exp_f, got);
				else if (got.tag != exp_f.tag) report("tag", exp_f, got);
				else if (got.tip != exp_f.tip) report("target_ip", exp_f, got);
				else if (got.tmac != exp_f.tmac) report("target_mac", exp_f, got);
				else if (got.last != exp_f.last) report("last", exp_f, got);
			end
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [47:0] val);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		case (idx)
			arp_pkg::REG_MAC: m_mac = val;
			arp_pkg::REG_IP: m_ip = val[31:0];
			arp_pkg::REG_LIFE: m_life = val[15:0];
			default: m_hold = val[15:0];
		endcase
	endtask

	task automatic wait_idle();
		while (expected_frames.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// one transfer on the command side, with random idle gaps
	task automatic issue(arp_item_t it);
		if (!quiet && $urandom_range(99) < 25) repeat ($urandom_range(6, 1)) @(posedge clk);
		start <= 1;
		{cmd, datagram_tag, hop_addr, frame_dst_mac, frame_is_ipv4, parse_ok,
			arp_is_request, arp_sender_ip, arp_sender_mac, arp_target_ip, elapsed_ms} <= it;
		do @(posedge clk); while (busy);
		start <= 0;
		resolve_item(it);
		@(posedge clk);
	endtask

	function automatic arp_item_t blank(logic [1:0] c);
		arp_item_t it;
		it = '0; it.cmd = c; it.ok = 1;
		return it;
	endfunction

	function automatic arp_item_t rand_item();
		arp_item_t it;
		int sel;
		it = '0;
		sel = $urandom_range(99);
		it.tag = 8'($urandom);
		it.hop = ip_pool[$urandom_range(7)];
		it.sip = ip_pool[$urandom_range(7)];
		it.smac = ($urandom_range(3) == 0) ? 48'({$urandom, $urandom})
			: mac_pool[$urandom_range(3)];
		it.tip = ($urandom_range(1) == 1) ? m_ip : 32'($urandom);
		it.fdst = ($urandom_range(9) < 4) ? m_mac
			: ($urandom_range(9) < 8) ? arp_pkg::BCAST_MAC : 48'({$urandom, $urandom});
		it.is_req = ($urandom_range(1) == 1);
		it.ok = ($urandom_range(9) != 0);
		it.dt = 16'($urandom_range(4000));
		if (sel < 40) it.cmd = arp_pkg::CMD_SEND;
		else if (sel < 75) it.cmd = arp_pkg::CMD_RECV;
		else if (sel < 95) begin
			it.cmd = arp_pkg::CMD_TICK;
			it.dt = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4000));
		end else it.cmd = arp_pkg::CMD_RSVD;
		if (it.cmd == arp_pkg::CMD_RECV) it.is_ipv4 = ($urandom_range(3) == 0);
		return it;
	endfunction

	arp_row_t rows[$];

	task automatic build_table();
		arp_row_t r;
		arp_item_t it;
		// receive ipv4 at reset mac zero: delivered up with its tag
		it = blank(arp_pkg::CMD_RECV); it.is_ipv4 = 1; it.tag = 8'hFF;
		r.item = it; r.has_typed = 1;
		r.typed = mk(arp_pkg::KIND_UP, 0, 8'hFF, 0, 0); r.typed.last = 1;
		rows = {rows, r};
		// send to unknown ip: request broadcast
		it = blank(arp_pkg::CMD_SEND); it.hop = 32'hFFFFFFFF; it.tag = 8'h00;
		r.item = it;
		r.typed = mk(arp_pkg::KIND_REQ, arp_pkg::BCAST_MAC, 0, 32'hFFFFFFFF, 0);
		r.typed.last = 1;
		rows = {rows, r};
		// same ip within holdoff: queued silently
		it.tag = 8'hA5; r.item = it; r.has_typed = 0; rows = {rows, r};
		r.has_typed = 0;
		// broadcast arp request targeting our ip (0) releases both, then replies
		it = blank(arp_pkg::CMD_RECV); it.fdst = arp_pkg::BCAST_MAC; it.is_req = 1;
		it.sip = 32'hFFFFFFFF; it.smac = 48'hFFFF_FFFF_FFFF; it.tip = 0;
		r.item = it; rows = {rows, r};
		// cache hit
		it = blank(arp_pkg::CMD_SEND); it.hop = 32'hFFFFFFFF; it.tag = 8'h3C;
		r.item = it; rows = {rows, r};
		// parse failure, wrong mac: ignored
		it = blank(arp_pkg::CMD_RECV); it.ok = 0; it.is_ipv4 = 1; r.item = it; rows = {rows, r};
		it = blank(arp_pkg::CMD_RECV); it.fdst = 48'h1; it.is_ipv4 = 1;
		r.item = it; rows = {rows, r};
		// unknown command
		it = blank(arp_pkg::CMD_RSVD); r.item = it; rows = {rows, r};
		// refresh an existing mapping with a zero mac
		it = blank(arp_pkg::CMD_RECV); it.sip = 32'hFFFFFFFF; it.smac = 0;
		r.item = it; rows = {rows, r};
		// fill the cache past its depth to force eviction
		for (int i = 0; i < NC + 2; i++) begin
			it = blank(arp_pkg::CMD_RECV); it.sip = 32'h0A000000 + i;
			it.smac = 48'h0200_0000_0000 + i;
			r.item = it; rows = {rows, r};
			if (i == 3) begin
				it = blank(arp_pkg::CMD_TICK); it.dt = 16'd7; r.item = it; rows = {rows, r};
			end
		end
		// saturating age: tick with max elapsed clears everything
		it = blank(arp_pkg::CMD_TICK); it.dt = 16'hFFFF; r.item = it; rows = {rows, r};
		it.dt = 16'hFFFF; r.item = it; rows = {rows, r};
		// overflow the pending queue: many sends, distinct ips overfill requests
		for (int i = 0; i < NP + 2; i++) begin
			it = blank(arp_pkg::CMD_SEND); it.hop = 32'hC0A80000 + (i % 10); it.tag = 8'(i);
			r.item = it; rows = {rows, r};
		end
		// a plain reply releasing one ip, no arp reply since not a request
		it = blank(arp_pkg::CMD_RECV); it.sip = 32'hC0A80001; it.smac = 48'h1234_5678_9ABC;
		r.item = it; rows = {rows, r};
	endtask

	initial begin
		arst_n = 0; start = 0; cfg_valid = 0; cfg_index = arp_pkg::REG_MAC; cfg_data = 0;
		{cmd, datagram_tag, hop_addr, frame_dst_mac, frame_is_ipv4, parse_ok,
			arp_is_request, arp_sender_ip, arp_sender_mac, arp_target_ip, elapsed_ms} = '0;
		m_mac = 0; m_ip = 0; m_life = arp_pkg::LIFETIME_RST; m_hold = arp_pkg::HOLDOFF_RST;
		for (int i = 0; i < NC; i++) begin c_v[i] = 0; c_age[i] = 0; end
		for (int i = 0; i < NR; i++) begin r_v[i] = 0; r_age[i] = 0; end
		pend_n = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed pass at reset configuration
		build_table();
		foreach (rows[i]) begin
			issue(rows[i].item);
			// replace predicted entry with the typed value for that row
			if (rows[i].has_typed)
				expected_frames[expected_frames.size()-1] = rows[i].typed;
		end
		wait_idle();

		// random phases, each under its own register setting
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					write_reg(arp_pkg::REG_MAC, 48'hFFFF_FFFF_FFFF);
					write_reg(arp_pkg::REG_IP, 48'hFFFFFFFF);
					write_reg(arp_pkg::REG_LIFE, 48'd0); write_reg(arp_pkg::REG_HOLD, 48'd0);
				end
				1: begin
					write_reg(arp_pkg::REG_MAC, 48'({$urandom, $urandom}));
					write_reg(arp_pkg::REG_IP, 48'($urandom));
					write_reg(arp_pkg::REG_LIFE, 48'hFFFF); write_reg(arp_pkg::REG_HOLD, 48'hFFFF);
				end
				2: begin
					write_reg(arp_pkg::REG_MAC, 48'h0); write_reg(arp_pkg::REG_IP, 48'h0);
					write_reg(arp_pkg::REG_LIFE, 48'($urandom_range(9000)));
					write_reg(arp_pkg::REG_HOLD, 48'($urandom_range(65535)));
				end
				default: begin
					write_reg(arp_pkg::REG_MAC, 48'({$urandom, $urandom}));
					write_reg(arp_pkg::REG_IP, 48'($urandom));
					write_reg(arp_pkg::REG_LIFE, 48'($urandom_range(65535)));
					write_reg(arp_pkg::REG_HOLD, 48'($urandom_range(3000)));
				end
			endcase
			for (int i = 0; i < 8; i++) ip_pool[i] = (i == 0) ? m_ip : 32'($urandom);
			for (int i = 0; i < 4; i++) mac_pool[i] = 48'({$urandom, $urandom});
			// third phase runs with no idle gaps
			quiet = (ph == 2);
			for (int n = 0; n < 28; n++) issue(rand_item());
			quiet = 0;
			wait_idle();
		end

		repeat (SETTLE) @(posedge clk);
		if (err_count == 0 && expected_frames.size() == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule

### arp_resolver_with_pending_queue.f
+incdir+rtl
rtl/arp_pkg.sv
rtl/arp_resolver_with_pending_queue.sv
verif/tb_arp_resolver_with_pending_queue.sv
